FILE: hdl/i2c_mra_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the I2C register access sequencer.
package i2c_mra_pkg;

	localparam int COUNT_BITS_DEFAULT = 16;
	localparam int SLOT_BITS = 16;
	localparam logic [SLOT_BITS-1:0] SLOT_RESET = 16'd1;

	// command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_BEGIN = 1'b1;

	// R/W bit appended to the device address
	localparam logic RW_WRITE = 1'b0;
	localparam logic RW_READ  = 1'b1;

	typedef enum logic [14:0] {
		PH_IDLE   = 15'h0001,
		PH_START1 = 15'h0002,
		PH_ADDRW  = 15'h0004,
		PH_ACK1   = 15'h0008,
		PH_REG    = 15'h0010,
		PH_ACK2   = 15'h0020,
		PH_START2 = 15'h0040,
		PH_ADDRR  = 15'h0080,
		PH_ACK3   = 15'h0100,
		PH_RREL   = 15'h0200,
		PH_RBYTE  = 15'h0400,
		PH_SACK   = 15'h0800,
		PH_WBYTE  = 15'h1000,
		PH_WACK   = 15'h2000,
		PH_STOP   = 15'h4000
	} phase_t;

	typedef struct packed {
		logic        command;
		logic        is_read;
		logic [6:0]  target_addr;
		logic [7:0]  start_reg;
		logic [15:0] count;
		logic [7:0]  write_byte;
		logic        sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       write_taken;
		logic       read_valid;
		logic [7:0] read_data;
		logic       read_last;
		logic       ack_valid;
		logic       ack_bit;
		logic       done_res;
	} result_t;

endpackage

FILE: hdl/i2c_mra_seq.sv
`timescale 1ns / 1ps
// Line-step sequencer: transfer state, slot timer and one-item step logic.
module i2c_mra_seq import i2c_mra_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [SLOT_BITS-1:0] cfg_data,
	input  logic                 accept,
	input  item_t                item,
	output result_t              res
);

	phase_t                phase_q, n_phase;
	logic [1:0]            step_q, n_step;
	logic [2:0]            bit_q, n_bit;
	logic [7:0]            shift_q, n_shift;
	logic [COUNT_BITS-1:0] left_q, n_left, left_dec;
	logic [SLOT_BITS-1:0]  timer_q, n_timer, slot_q, reload;
	logic                  scl_q, n_scl, sda_q, n_sda;
	logic [6:0]            dev_q;
	logic [7:0]            reg_q, send_src, rx_byte;
	logic                  rd_q;

	assign left_dec = left_q - COUNT_BITS'(1);
	assign reload   = (slot_q == '0) ? '0 : slot_q - SLOT_BITS'(1);
	assign rx_byte  = {shift_q[6:0], item.sda_in};

	always_comb begin
		unique case (phase_q) inside
			PH_ADDRW: send_src = {dev_q, RW_WRITE};
			PH_ADDRR: send_src = {dev_q, RW_READ};
			PH_REG:   send_src = reg_q;
			default:  send_src = item.write_byte;
		endcase
	end

	always_comb begin
		n_phase = phase_q;
		n_step  = step_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_left  = left_q;
		n_timer = timer_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		res     = '0;
		if (accept) begin
			if (item.command == CMD_BEGIN) begin
				if (phase_q == PH_IDLE) begin
					n_phase = PH_START1;
					n_step  = '0;
					n_bit   = '0;
					n_shift = '0;
					n_timer = '0;
					n_left  = item.count[COUNT_BITS-1:0];
				end
			end else if (phase_q != PH_IDLE) begin
				if (timer_q != '0) begin
					n_timer = timer_q - SLOT_BITS'(1);
				end else begin
					n_timer = reload;
					unique case (phase_q) inside
						PH_START1, PH_START2: begin
							n_step = step_q + 2'd1;
							case (step_q)
								2'd0: n_sda = 1'b1;
								2'd1: n_scl = 1'b1;
								2'd2: n_sda = 1'b0;
								default: begin
									n_scl   = 1'b0;
									n_step  = '0;
									n_bit   = '0;
									n_phase = (phase_q == PH_START1) ? PH_ADDRW : PH_ADDRR;
								end
							endcase
						end
						PH_STOP: begin
							n_step = step_q + 2'd1;
							case (step_q)
								2'd0: n_scl = 1'b0;
								2'd1: n_sda = 1'b0;
								2'd2: n_scl = 1'b1;
								default: begin
									n_sda        = 1'b1;
									n_step       = '0;
									n_bit        = '0;
									n_phase      = PH_IDLE;
									res.done_res = 1'b1;
								end
							endcase
						end
						PH_ACK1, PH_ACK2, PH_ACK3, PH_WACK: begin
							n_step = step_q + 2'd1;
							case (step_q)
								2'd0: n_sda = 1'b1;
								2'd1: n_scl = 1'b1;
								2'd2: begin
									res.ack_valid = 1'b1;
									res.ack_bit   = item.sda_in;
								end
								default: begin
									n_scl  = 1'b0;
									n_step = '0;
									n_bit  = '0;
									case (phase_q)
										PH_ACK1: n_phase = PH_REG;
										PH_ACK2: begin
											if (rd_q)
												n_phase = PH_START2;
											else
												n_phase = (left_q != '0) ? PH_WBYTE : PH_STOP;
										end
										PH_ACK3: n_phase = (left_q != '0) ? PH_RREL : PH_STOP;
										default: begin
											n_left  = left_dec;
											n_phase = (left_dec != '0) ? PH_WBYTE : PH_STOP;
										end
									endcase
								end
							endcase
						end
						PH_ADDRW, PH_REG, PH_ADDRR, PH_WBYTE: begin
							if (phase_q == PH_WBYTE && bit_q == '0 && step_q == '0)
								res.write_taken = 1'b1;
							if (step_q == 2'd0) begin
								if (bit_q == '0) begin
									n_shift = send_src;
									n_sda   = send_src[7];
								end else begin
									n_sda = shift_q[7];
								end
								n_step = 2'd1;
							end else if (step_q == 2'd1) begin
								n_scl  = 1'b1;
								n_step = 2'd2;
							end else begin
								n_scl   = 1'b0;
								n_shift = {shift_q[6:0], 1'b0};
								n_step  = '0;
								n_bit   = bit_q + 3'd1;
								if (bit_q == 3'd7) begin
									case (phase_q)
										PH_ADDRW: n_phase = PH_ACK1;
										PH_REG:   n_phase = PH_ACK2;
										PH_ADDRR: n_phase = PH_ACK3;
										default:  n_phase = PH_WACK;
									endcase
								end
							end
						end
						PH_RREL: begin
							n_sda   = 1'b1;
							n_shift = '0;
							n_step  = '0;
							n_bit   = '0;
							n_phase = PH_RBYTE;
						end
						PH_RBYTE: begin
							if (step_q == 2'd0) begin
								n_scl  = 1'b1;
								n_step = 2'd1;
							end else if (step_q == 2'd1) begin
								n_shift = rx_byte;
								if (bit_q == 3'd7) begin
									res.read_valid = 1'b1;
									res.read_data  = rx_byte;
									res.read_last  = (left_q == COUNT_BITS'(1));
								end
								n_step = 2'd2;
							end else begin
								n_scl  = 1'b0;
								n_step = '0;
								n_bit  = bit_q + 3'd1;
								if (bit_q == 3'd7)
									n_phase = PH_SACK;
							end
						end
						PH_SACK: begin
							if (step_q == 2'd0) begin
								n_sda  = (left_q == COUNT_BITS'(1));
								n_step = 2'd1;
							end else if (step_q == 2'd1) begin
								n_scl  = 1'b1;
								n_step = 2'd2;
							end else begin
								n_scl   = 1'b0;
								n_left  = left_dec;
								n_step  = '0;
								n_bit   = '0;
								n_phase = (left_dec != '0) ? PH_RREL : PH_STOP;
							end
						end
						default: begin
							n_phase = PH_IDLE;
							n_step  = '0;
							n_bit   = '0;
						end
					endcase
				end
			end
		end
		res.scl_level = n_scl;
		res.sda_level = n_sda;
		res.busy_res  = (n_phase != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			step_q  <= '0;
			bit_q   <= '0;
			left_q  <= '0;
			timer_q <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			rd_q    <= 1'b0;
			slot_q  <= SLOT_RESET;
		end else begin
			if (cfg_we)
				slot_q <= cfg_data;
			if (accept) begin
				phase_q <= n_phase;
				step_q  <= n_step;
				bit_q   <= n_bit;
				left_q  <= n_left;
				timer_q <= n_timer;
				scl_q   <= n_scl;
				sda_q   <= n_sda;
				if (item.command == CMD_BEGIN && phase_q == PH_IDLE)
					rd_q <= item.is_read;
			end
		end
	end

	// Payload registers: latched on begin, shifted on steps.
	always_ff @(posedge clk) begin
		if (accept) begin
			shift_q <= n_shift;
			if (item.command == CMD_BEGIN && phase_q == PH_IDLE) begin
				dev_q <= item.target_addr;
				reg_q <= item.start_reg;
			end
		end
	end

endmodule

FILE: hdl/i2c_mra_outreg.sv
`timescale 1ns / 1ps
// Result register with valid/stall handshake toward the consumer.
module i2c_mra_outreg import i2c_mra_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	input  logic    result_stall,
	output logic    result_valid,
	output result_t result,
	output logic    full_stalled
);

	logic    valid_q;
	result_t res_q;

	assign full_stalled = valid_q & result_stall;
	assign result_valid = valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (!result_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_in;
	end

endmodule

FILE: hdl/i2c_master_register_access_core.sv
`timescale 1ns / 1ps
// Top level of the I2C master register access sequencer.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_stall      item_t   (command, tick data, sda_in)
//   result    out        result_valid / result_stall  result_t (line levels, status, data)
//   cfg       in         cfg_we                       cfg_data (slot_length)
//
// One transaction per cycle while item_stall is low: a transaction is taken and stepped
// in the cycle it arrives, and its result shows in the result register on the next cycle.
// The only wait comes from the result register: item_stall rises when it holds
// a result that the consumer is stalling; a new transaction is taken in the same
// cycle the held result drains.
// Reset leaves both lines released, the sequencer idle and slot_length at one.
module i2c_master_register_access_core import i2c_mra_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [SLOT_BITS-1:0] cfg_data,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result
);

	logic    accept;
	logic    full_stalled;
	result_t step_res;

	// Hold the input while the result register cannot drain.
	assign item_stall = full_stalled;
	assign accept     = item_valid & ~full_stalled;

	// Advance the sequencer by one transaction on every accept.
	i2c_mra_seq #(
		.COUNT_BITS(COUNT_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.accept   (accept),
		.item     (item),
		.res      (step_res)
	);

	// Capture the step result and present it to the consumer.
	i2c_mra_outreg u_outreg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.res_in       (step_res),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.full_stalled (full_stalled)
	);

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the I2C register access sequencer: directed and random transfers.
module tb;
	import i2c_mra_pkg::*;

	localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction on either side
	localparam int HOLD_CYCLES  = 300;   // long receiver hold-off for the backpressure test
	localparam int MAX_REPORTS  = 100;
	localparam int RANDOM_ITEMS = 300;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [SLOT_BITS-1:0] cfg_data = '0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	item_t                item = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;

	i2c_master_register_access_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Bus sequencer mirror: line levels, phase and counters after each accepted transaction.
	phase_t      bus_phase = PH_IDLE;
	logic [1:0]  bus_step = '0;
	logic [3:0]  bit_cnt = '0;
	logic [7:0]  shreg = '0;
	logic [15:0] bytes_left = '0;
	logic [15:0] slot_timer = '0;
	logic        scl_q = 1'b1;
	logic        sda_q = 1'b1;
	logic [6:0]  dev_q = '0;
	logic [7:0]  reg_q = '0;
	logic        rd_q = 1'b0;
	logic [15:0] slot_len = SLOT_RESET;
	result_t     line_out;

	result_t expected_lines[$];
	int      mismatch_cnt = 0;
	int      quiet_cycles = 0;
	int      items_sent = 0;
	bit      pace_items = 1'b1;
	bit      pace_results = 1'b1;
	bit      hold_req = 1'b0;

	function automatic void goto_phase(phase_t p);
		bus_phase = p;
		bus_step = 2'd0;
		bit_cnt = 4'd0;
	endfunction

	// One step of shifting a byte out MSB first; the byte is loaded on the first step.
	function automatic logic shift_out_step(logic [7:0] src);
		case (bus_step)
		2'd0: begin
			if (bit_cnt == 4'd0)
				shreg = src;
			sda_q = shreg[7];
			bus_step = 2'd1;
		end
		2'd1: begin
			scl_q = 1'b1;
			bus_step = 2'd2;
		end
		default: begin
			scl_q = 1'b0;
			shreg = {shreg[6:0], 1'b0};
			bus_step = 2'd0;
			bit_cnt++;
			if (bit_cnt >= 4'd8) begin
				bit_cnt = 4'd0;
				return 1'b1;
			end
		end
		endcase
		return 1'b0;
	endfunction

	// Start and stop conditions are four line steps each.
	function automatic logic bus_condition_step(logic is_start);
		case (bus_step)
		2'd0: if (is_start) sda_q = 1'b1; else scl_q = 1'b0;
		2'd1: if (is_start) scl_q = 1'b1; else sda_q = 1'b0;
		2'd2: if (is_start) sda_q = 1'b0; else scl_q = 1'b1;
		default: begin
			if (is_start) scl_q = 1'b0; else sda_q = 1'b1;
			return 1'b1;
		end
		endcase
		bus_step++;
		return 1'b0;
	endfunction

	function automatic logic sample_ack(logic sda);
		case (bus_step)
		2'd0: sda_q = 1'b1;
		2'd1: scl_q = 1'b1;
		2'd2: begin
			line_out.ack_valid = 1'b1;
			line_out.ack_bit = sda;
		end
		default: begin
			scl_q = 1'b0;
			return 1'b1;
		end
		endcase
		bus_step++;
		return 1'b0;
	endfunction

	function automatic void line_step(logic [7:0] wbyte, logic sda);
		case (bus_phase)
		PH_START1: if (bus_condition_step(1'b1)) goto_phase(PH_ADDRW);
		PH_ADDRW:  if (shift_out_step({dev_q, RW_WRITE})) goto_phase(PH_ACK1);
		PH_ACK1:   if (sample_ack(sda)) goto_phase(PH_REG);
		PH_REG:    if (shift_out_step(reg_q)) goto_phase(PH_ACK2);
		PH_ACK2:   if (sample_ack(sda)) begin
			if (rd_q)
				goto_phase(PH_START2);
			else
				goto_phase(bytes_left != 16'd0 ? PH_WBYTE : PH_STOP);
		end
		PH_START2: if (bus_condition_step(1'b1)) goto_phase(PH_ADDRR);
		PH_ADDRR:  if (shift_out_step({dev_q, RW_READ})) goto_phase(PH_ACK3);
		PH_ACK3:   if (sample_ack(sda)) goto_phase(bytes_left != 16'd0 ? PH_RREL : PH_STOP);
		PH_RREL: begin
			sda_q = 1'b1;
			shreg = 8'd0;
			goto_phase(PH_RBYTE);
		end
		PH_RBYTE: begin
			if (bus_step == 2'd0) begin
				scl_q = 1'b1;
				bus_step = 2'd1;
			end else if (bus_step == 2'd1) begin
				shreg = {shreg[6:0], sda};
				if (bit_cnt == 4'd7) begin
					line_out.read_valid = 1'b1;
					line_out.read_data = shreg;
					line_out.read_last = (bytes_left == 16'd1);
				end
				bus_step = 2'd2;
			end else begin
				scl_q = 1'b0;
				bus_step = 2'd0;
				bit_cnt++;
				if (bit_cnt >= 4'd8)
					goto_phase(PH_SACK);
			end
		end
		PH_SACK: begin
			// ACK every byte but the last, which gets NACK
			if (bus_step == 2'd0) begin
				sda_q = (bytes_left == 16'd1);
				bus_step = 2'd1;
			end else if (bus_step == 2'd1) begin
				scl_q = 1'b1;
				bus_step = 2'd2;
			end else begin
				scl_q = 1'b0;
				bytes_left--;
				goto_phase(bytes_left != 16'd0 ? PH_RREL : PH_STOP);
			end
		end
		PH_WBYTE: begin
			if (bit_cnt == 4'd0 && bus_step == 2'd0)
				line_out.write_taken = 1'b1;
			if (shift_out_step(wbyte))
				goto_phase(PH_WACK);
		end
		PH_WACK: if (sample_ack(sda)) begin
			bytes_left--;
			goto_phase(bytes_left != 16'd0 ? PH_WBYTE : PH_STOP);
		end
		PH_STOP: if (bus_condition_step(1'b0)) begin
			line_out.done_res = 1'b1;
			goto_phase(PH_IDLE);
		end
		default: goto_phase(PH_IDLE);
		endcase
	endfunction

	// Advance the mirror by one transaction and return the result it must produce.
	function automatic result_t predict_lines(item_t it);
		line_out = '0;
		if (it.command == CMD_BEGIN) begin
			// a begin while busy is dropped entirely
			if (bus_phase == PH_IDLE) begin
				rd_q = it.is_read;
				dev_q = it.target_addr;
				reg_q = it.start_reg;
				bytes_left = it.count;
				shreg = 8'd0;
				slot_timer = 16'd0;
				goto_phase(PH_START1);
			end
		end else if (bus_phase != PH_IDLE) begin
			if (slot_timer != 16'd0) begin
				slot_timer--;
			end else begin
				line_step(it.write_byte, it.sda_in);
				slot_timer = (slot_len == 16'd0) ? 16'd0 : slot_len - 16'd1;
			end
		end
		line_out.scl_level = scl_q;
		line_out.sda_level = sda_q;
		line_out.busy_res = (bus_phase != PH_IDLE);
		return line_out;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pause_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic item_t make_tick(int fixed_byte, int sda_mode);
		item_t it;
		it.command = CMD_TICK;
		it.is_read = 1'($urandom_range(0, 1));
		it.target_addr = 7'($urandom_range(0, 127));
		it.start_reg = 8'($urandom_range(0, 255));
		it.count = 16'($urandom_range(0, 65535));
		it.write_byte = (fixed_byte < 0) ? 8'($urandom_range(0, 255)) : fixed_byte[7:0];
		it.sda_in = (sda_mode < 0) ? 1'($urandom_range(0, 1)) : sda_mode[0];
		return it;
	endfunction

	function automatic item_t make_begin(logic rd, logic [6:0] dev, logic [7:0] regnum,
			logic [15:0] cnt);
		item_t it;
		it.command = CMD_BEGIN;
		it.is_read = rd;
		it.target_addr = dev;
		it.start_reg = regnum;
		it.count = cnt;
		it.write_byte = 8'($urandom_range(0, 255));
		it.sda_in = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// Offer one transaction, hold it until taken, then predict and maybe idle.
	task automatic send_item(item_t it);
		int gap;
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if ((it.command == CMD_BEGIN) == (bus_phase == PH_IDLE))
			items_sent++;
		expected_lines.push_back(predict_lines(it));
		gap = pace_items ? pause_cycles() : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Tick until the sequencer is back to idle; noise mixes in begins that must be dropped.
	task automatic finish_transfer(int fixed_byte, int sda_mode, int noise);
		while (bus_phase != PH_IDLE) begin
			if ($urandom_range(1, 100) <= noise)
				send_item(make_begin(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
					8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535))));
			else
				send_item(make_tick(fixed_byte, sda_mode));
		end
	endtask

	task automatic run_transfer(logic rd, logic [6:0] dev, logic [7:0] regnum, logic [15:0] cnt,
			int fixed_byte, int sda_mode, int noise);
		send_item(make_begin(rd, dev, regnum, cnt));
		finish_transfer(fixed_byte, sda_mode, noise);
	endtask

	// Write slot_length with the handshake drained.
	task automatic write_slot_length(logic [15:0] value);
		item_valid <= 1'b0;
		while (expected_lines.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_data <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		slot_len = value;
	endtask

	task automatic test_idle_ticks();
		// lines must stay released
		repeat (6) send_item(make_tick(-1, -1));
	endtask

	task automatic test_write_extremes();
		run_transfer(RW_WRITE, 7'h7F, 8'hFF, 16'd1, 8'hFF, 1, 0);
		run_transfer(RW_WRITE, 7'h00, 8'h00, 16'd2, 8'h00, 0, 0);
	endtask

	task automatic test_read_extremes();
		run_transfer(RW_READ, 7'h7F, 8'hFF, 16'd1, -1, 1, 0);
		run_transfer(RW_READ, 7'h00, 8'h00, 16'd2, -1, 0, 0);
		run_transfer(RW_READ, 7'h2D, 8'h96, 16'd3, -1, -1, 0);
	endtask

	task automatic test_zero_count();
		run_transfer(RW_READ, 7'h15, 8'h3A, 16'd0, -1, -1, 0);
		run_transfer(RW_WRITE, 7'h6A, 8'hC5, 16'd0, -1, -1, 0);
	endtask

	task automatic test_busy_begin();
		send_item(make_begin(RW_READ, 7'h33, 8'h44, 16'd1));
		send_item(make_begin(RW_WRITE, 7'h7F, 8'hFF, 16'hFFFF));
		send_item(make_begin(RW_READ, 7'h00, 8'h00, 16'h8000));
		finish_transfer(-1, -1, 40);
	endtask

	task automatic test_slot_lengths();
		// zero behaves as one
		write_slot_length(16'd0);
		run_transfer(RW_READ, 7'h2A, 8'h55, 16'd2, -1, -1, 0);
		write_slot_length(16'd3);
		run_transfer(RW_WRITE, 7'h55, 8'hAA, 16'd2, -1, -1, 5);
		// long slot: take the first step, then shorten while the countdown runs out
		pace_items = 1'b0;
		pace_results = 1'b0;
		write_slot_length(16'd40);
		send_item(make_begin(RW_WRITE, 7'h11, 8'h22, 16'd1));
		send_item(make_tick(-1, -1));
		write_slot_length(16'd1);
		finish_transfer(-1, -1, 0);
		pace_items = 1'b1;
		pace_results = 1'b1;
	endtask

	task automatic test_backpressure();
		// receiver holds off while items keep coming, so the block must stall its input
		pace_items = 1'b0;
		pace_results = 1'b0;
		hold_req = 1'b1;
		run_transfer(RW_WRITE, 7'h3C, 8'hC3, 16'd3, -1, -1, 0);
		hold_req = 1'b1;
		run_transfer(RW_READ, 7'h5A, 8'h0F, 16'd2, -1, -1, 0);
		pace_items = 1'b1;
		pace_results = 1'b1;
	endtask

	task automatic test_long_read();
		// several bytes in a row with stray begins mixed in
		run_transfer(RW_READ, 7'h6B, 8'h80, 16'd3, -1, -1, 2);
	endtask

	task automatic test_random_traffic();
		int first;
		int pick;
		logic [15:0] cnt;
		first = items_sent;
		while (items_sent - first < RANDOM_ITEMS) begin
			pace_items = ($urandom_range(0, 4) != 0);
			pace_results = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 7) == 0) begin
				pick = $urandom_range(0, 9);
				write_slot_length(pick == 0 ? 16'd0 : pick < 7 ? 16'd1 : pick < 9 ? 16'd2 : 16'd5);
			end
			if ($urandom_range(0, 19) == 0)
				repeat ($urandom_range(1, 4)) send_item(make_tick(-1, -1));
			cnt = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(4, 12)) :
				16'($urandom_range(0, 3));
			run_transfer(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
				8'($urandom_range(0, 255)), cnt, -1, -1, 5);
		end
	endtask

	// Receiver pacing; a hold-off request wins over random stalls.
	always begin : result_pacing
		int n;
		@(posedge clk);
		if (hold_req) begin
			hold_req = 1'b0;
			n = HOLD_CYCLES;
		end else begin
			n = pace_results ? pause_cycles() : 0;
		end
		if (n > 0) begin
			result_stall <= 1'b1;
			repeat (n) @(posedge clk);
		end
		result_stall <= 1'b0;
	end

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			mismatch_cnt++;
			if (mismatch_cnt <= MAX_REPORTS)
				$display("%0d ns: %s expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// Compare every result taken against the oldest prediction.
	always @(posedge clk) begin : result_check
		result_t want;
		if (result_valid && !result_stall) begin
			if (expected_lines.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS)
					$display("%0d ns: result expected none, actual %h", $time, result);
			end else begin
				want = expected_lines.pop_front();
				check_field("scl_level", want.scl_level, result.scl_level);
				check_field("sda_level", want.sda_level, result.sda_level);
				check_field("busy_res", want.busy_res, result.busy_res);
				check_field("write_taken", want.write_taken, result.write_taken);
				check_field("read_valid", want.read_valid, result.read_valid);
				check_field("read_data", want.read_data, result.read_data);
				check_field("read_last", want.read_last, result.read_last);
				check_field("ack_valid", want.ack_valid, result.ack_valid);
				check_field("ack_bit", want.ack_bit, result.ack_bit);
				check_field("done_res", want.done_res, result.done_res);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ticks();
		test_write_extremes();
		test_read_extremes();
		test_zero_count();
		test_busy_begin();
		test_slot_lengths();
		test_backpressure();
		test_long_read();
		test_random_traffic();
		// drain, then give the result register time to show anything extra
		item_valid <= 1'b0;
		while (expected_lines.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
